FILE: rtl/core/lnpva_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lnpva_pkg
// shared types and codes of the last-note-priority voice allocator
// ----------------------------------------------------------------------------
package lnpva_pkg;

   // width of a note number and of a voice code on the ports
   localparam int FIELD_W = 7;

   typedef logic [FIELD_W-1:0] field_type;

   // event operation codes
   localparam logic OP_NOTE_ON  = 1'b0;
   localparam logic OP_NOTE_OFF = 1'b1;

endpackage : lnpva_pkg

`default_nettype wire

FILE: rtl/core/lnpva_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lnpva_ram
// generic single-write, single-read ram with a registered read port
// ----------------------------------------------------------------------------
module lnpva_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 84,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule : lnpva_ram

`default_nettype wire

FILE: rtl/core/last_note_priority_voice_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// last_note_priority_voice_allocator
// most-recent-first note list kept in linked-list rams, three voice outputs
// ----------------------------------------------------------------------------
// usage
//  - req channel (valid/ready): one note event per word, req_operation is
//    note on or note off, req_note is the note number; notes at or above
//    NOTE_COUNT are ignored but still answered
//  - rsp channel (valid/ready): one word per event with the three most
//    recent sounding notes; silent voices carry the code NOTE_COUNT
//  - sequence: from accept, an optional unlink and an optional push, then
//    the list walk does one ram read of the older-link memory per voice;
//    one event is in flight at a time, so a new event is taken the cycle
//    after the result is loaded into the output register
//  - the output register holds the result while the receiver stalls; the
//    next event is accepted meanwhile and its result waits until the held
//    word is taken
//  - reset: synchronous, active high; empties the list (all voices silent)
//    and drops any pending word; the link rams need no clearing pass
// ----------------------------------------------------------------------------
module last_note_priority_voice_allocator #(
   parameter int NOTE_COUNT  = 84,
   parameter int VOICE_COUNT = 3
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_operation,
   input  wire lnpva_pkg::field_type  req_note,

   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output lnpva_pkg::field_type       rsp_voice_first,
   output lnpva_pkg::field_type       rsp_voice_second,
   output lnpva_pkg::field_type       rsp_voice_third
);

   import lnpva_pkg::*;

   // entries 0..NOTE_COUNT-1 are notes, the rest are the silence tail
   localparam int ENTRY_COUNT = NOTE_COUNT + VOICE_COUNT;
   localparam int EW          = $clog2(ENTRY_COUNT);
   localparam int AW          = $clog2(NOTE_COUNT);
   // voice slots: at least the three output fields
   localparam int VSLOTS      = (VOICE_COUNT > 3) ? VOICE_COUNT : 3;
   localparam int KW          = $clog2(VSLOTS);

   localparam field_type SILENCE = FIELD_W'(NOTE_COUNT);

   typedef enum logic [2:0] {
      S_IDLE,
      S_UNLINK,
      S_PUSH,
      S_START,
      S_WALK,
      S_NEXT,
      S_DONE
   } state_type;

   typedef logic [EW-1:0] entry_type;

   state_type              state_ff;
   entry_type              front_ff;
   entry_type              cur_ff;
   logic [KW-1:0]          k_ff;
   logic [NOTE_COUNT-1:0]  note_sounding_ff;
   logic                   op_ff;
   field_type              note_ff;
   logic                   in_range_ff;
   field_type              voices_ff [VSLOTS];
   logic                   rsp_valid_ff;
   field_type              rsp_first_ff;
   field_type              rsp_second_ff;
   field_type              rsp_third_ff;

   // link rams: only note entries are stored, silence entries chain by +1
   logic       older_we;
   logic [AW-1:0] older_wa;
   entry_type  older_wd;
   logic [AW-1:0] older_ra;
   entry_type  older_rdata;

   logic       newer_we;
   logic [AW-1:0] newer_wa;
   entry_type  newer_wd;
   entry_type  newer_rdata;

   logic       req_in_range;
   logic       req_sounding;
   logic       req_fire;
   logic       front_is_note;
   logic       front_is_target;
   logic       cur_is_note;
   logic       older_is_note;
   logic       out_load;

   assign req_in_range    = ({1'b0, req_note} < 8'(NOTE_COUNT));
   assign req_sounding    = note_sounding_ff[AW'(req_note)];
   assign req_ready       = (state_ff == S_IDLE);
   assign req_fire        = req_valid && req_ready;
   assign front_is_note   = (front_ff < EW'(NOTE_COUNT));
   assign front_is_target = (front_ff == EW'(note_ff));
   assign cur_is_note     = (cur_ff < EW'(NOTE_COUNT));
   assign older_is_note   = (older_rdata < EW'(NOTE_COUNT));
   assign out_load        = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // read address: the event's note at accept, the walk cursor later
   assign older_ra = (state_ff == S_IDLE) ? AW'(req_note) : AW'(cur_ff);

   // ram write control for unlink and push
   always_comb begin
      older_we = 1'b0;
      older_wa = AW'(note_ff);
      older_wd = front_ff;
      newer_we = 1'b0;
      newer_wa = AW'(front_ff);
      newer_wd = EW'(note_ff);
      unique case (state_ff)
         S_UNLINK: begin
            // bridge the neighbors unless the note is at the front
            older_we = !front_is_target;
            older_wa = AW'(newer_rdata);
            older_wd = older_rdata;
            newer_we = !front_is_target && older_is_note;
            newer_wa = AW'(older_rdata);
            newer_wd = newer_rdata;
         end
         S_PUSH: begin
            // new front points at the old front
            older_we = 1'b1;
            newer_we = front_is_note;
         end
         default: begin
         end
      endcase
   end

   lnpva_ram #(
      .WIDTH (EW),
      .DEPTH (NOTE_COUNT)
   ) u_older_ram (
      .clock   (clock),
      .wr_en   (older_we),
      .wr_addr (older_wa),
      .wr_data (older_wd),
      .rd_addr (older_ra),
      .rd_data (older_rdata)
   );

   lnpva_ram #(
      .WIDTH (EW),
      .DEPTH (NOTE_COUNT)
   ) u_newer_ram (
      .clock   (clock),
      .wr_en   (newer_we),
      .wr_addr (newer_wa),
      .wr_data (newer_wd),
      .rd_addr (AW'(req_note)),
      .rd_data (newer_rdata)
   );

   // sequencer: state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         front_ff         <= EW'(NOTE_COUNT);
         note_sounding_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         // output word: set when the walk result is loaded, cleared once taken
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  op_ff       <= req_operation;
                  note_ff     <= req_note;
                  in_range_ff <= req_in_range;
                  priority if (!req_in_range) begin
                     state_ff <= S_START;
                  end else if (req_sounding) begin
                     state_ff <= S_UNLINK;
                  end else if (req_operation == OP_NOTE_ON) begin
                     state_ff <= S_PUSH;
                  end else begin
                     state_ff <= S_START;
                  end
               end
            end
            S_UNLINK: begin
               if (front_is_target) begin
                  front_ff <= older_rdata;
               end
               note_sounding_ff[AW'(note_ff)] <= 1'b0;
               state_ff <= (op_ff == OP_NOTE_ON) ? S_PUSH : S_START;
            end
            S_PUSH: begin
               front_ff <= EW'(note_ff);
               note_sounding_ff[AW'(note_ff)] <= 1'b1;
               state_ff <= S_START;
            end
            S_START: begin
               cur_ff <= front_ff;
               k_ff   <= '0;
               for (int j = 0; j < VSLOTS; j++) begin
                  voices_ff[j] <= SILENCE;
               end
               state_ff <= S_WALK;
            end
            S_WALK: begin
               // older-link read of the cursor is issued this cycle
               voices_ff[k_ff] <= cur_is_note ? FIELD_W'(cur_ff) : SILENCE;
               state_ff <= (k_ff == KW'(VOICE_COUNT - 1)) ? S_DONE : S_NEXT;
            end
            S_NEXT: begin
               cur_ff   <= cur_is_note ? older_rdata : cur_ff + entry_type'(1);
               k_ff     <= k_ff + KW'(1);
               state_ff <= S_WALK;
            end
            S_DONE: begin
               if (out_load) begin
                  rsp_first_ff  <= voices_ff[0];
                  rsp_second_ff <= voices_ff[1];
                  rsp_third_ff  <= voices_ff[2];
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_voice_first  = rsp_first_ff;
   assign rsp_voice_second = rsp_second_ff;
   assign rsp_voice_third  = rsp_third_ff;

   // front note of a settled list is always sounding
   a_front_sounding: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && front_is_note) |-> note_sounding_ff[AW'(front_ff)])
      else $error("front entry is a silent note");

   // an in-range note-on always shows up as the first voice
   a_note_on_first: assert property (@(posedge clock) disable iff (reset)
      (out_load && op_ff == OP_NOTE_ON && in_range_ff)
      |=> (rsp_voice_first == $past(note_ff)))
      else $error("note-on not reported as first voice");

   // one event adds at most one note to the sounding set
   a_sounding_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ($countones(note_sounding_ff) <= $past($countones(note_sounding_ff)) + 1))
      else $error("sounding set grew by more than one note");

   // list entries are distinct, so two voices never share a note; checked here for the first and second voice
   a_voices_distinct: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_voice_first != SILENCE) |-> (rsp_voice_first != rsp_voice_second))
      else $error("first and second voice carry the same note");

endmodule : last_note_priority_voice_allocator

`default_nettype wire
